FILE: design/expr_tok_pkg.sv
// Shared types and constants for the expression tokenizer.
// No dependencies; the core module refers to these by scoped names.
package expr_tok_pkg;

  // Width of the text position counter (saturates at all ones).
  localparam int unsigned POS_BITS = 16;

  // Result queue between the scanner and the output channel.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_OP,
    MODE_ERROR
  } mode_t;

  localparam logic [3:0] KIND_EOF      = 4'd0;
  localparam logic [3:0] KIND_STRING   = 4'd1;
  localparam logic [3:0] KIND_IDENT    = 4'd2;
  localparam logic [3:0] KIND_IF       = 4'd3;
  localparam logic [3:0] KIND_NUMBER   = 4'd4;
  localparam logic [3:0] KIND_LPAREN   = 4'd5;
  localparam logic [3:0] KIND_RPAREN   = 4'd6;
  localparam logic [3:0] KIND_LBRACKET = 4'd7;
  localparam logic [3:0] KIND_RBRACKET = 4'd8;
  localparam logic [3:0] KIND_COMMA    = 4'd9;
  localparam logic [3:0] KIND_OP       = 4'd10;
  localparam logic [3:0] KIND_BOOLOP   = 4'd11;
  localparam logic [3:0] KIND_BADCHAR  = 4'd12;
  localparam logic [3:0] KIND_UNCLOSED = 4'd13;

  // Keyword tracking for "if".
  localparam logic [1:0] KW_NONE  = 2'd0;
  localparam logic [1:0] KW_SAW_I = 2'd1;
  localparam logic [1:0] KW_MATCH = 2'd2;
  localparam logic [1:0] KW_OTHER = 2'd3;

  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_EQ       = 8'h3D;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_PIPE     = 8'h7C;
  localparam logic [7:0] CH_UNDER    = 8'h5F;
  localparam logic [7:0] CH_LOWER_I  = 8'h69;
  localparam logic [7:0] CH_LOWER_F  = 8'h66;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_NUL      = 8'h00;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start_res;
    logic [15:0] length;
    logic        last_of_run;
  } out_t;

endpackage

FILE: design/expression_tokenizer_core.sv
// Streaming expression tokenizer: top level and only module.
// Depends on expr_tok_pkg for the channel structs, scan modes and codes.
//
// Usage:
//   in_valid/in_stall/in_data carry one text byte (or an end-of-text marker)
//   per transaction. A byte of zero also ends the text.
//   out_valid/out_stall/out_data carry one token per transaction: kind,
//   start position, length and last_of_run, which marks the final token
//   caused by one input transaction.
// The tokens caused by a byte are written into the registered result queue
// when the byte is accepted and are offered in order, the second one (if any)
// after the first. Throughput: one byte per cycle unless in_stall is high.
// The scanner decides each byte with a single pass of logic and pushes up to
// two tokens into a four-entry result queue; the queue drains one token per
// cycle unless out_stall is high, so bytes that cause two tokens in a row
// are limited by that output port.
// in_stall rises when the queue has fewer than two free entries, so a
// receiver that holds out_stall high backs up into the input once three or
// four tokens are buffered. No token is dropped or repeated.
// Reset (rst_n low, synchronous) empties the queue, returns the scanner to
// idle and sets the position counter to zero. The counter saturates.
module expression_tokenizer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  expr_tok_pkg::in_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output expr_tok_pkg::out_t  out_data
);

  localparam int unsigned PB = expr_tok_pkg::POS_BITS;
  localparam int unsigned AW = expr_tok_pkg::OUT_AW;
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == expr_tok_pkg::CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_opchar(input logic [7:0] c);
    return c == expr_tok_pkg::CH_EQ || c == expr_tok_pkg::CH_GT ||
           c == expr_tok_pkg::CH_LT || c == expr_tok_pkg::CH_BANG ||
           c == expr_tok_pkg::CH_AMP || c == expr_tok_pkg::CH_PIPE;
  endfunction

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] p);
    return (p == POS_MAX) ? p : p + 1'b1;
  endfunction

  // Scanner state.
  expr_tok_pkg::mode_t mode_r, mode_nxt;
  logic [PB-1:0] cursor_r, cursor_nxt;
  logic [PB-1:0] tok_begin_r, tok_begin_nxt;
  logic [7:0]    op_char_r, op_char_nxt;
  logic [1:0]    kw_r, kw_nxt;

  // Result queue.
  expr_tok_pkg::out_t fifo_r [expr_tok_pkg::OUT_DEPTH];
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;

  logic push, pop;
  logic [7:0] c;
  logic       text_end;
  logic [PB-1:0] p;
  logic [15:0]   span16;

  // Start-of-token decode of the current byte.
  expr_tok_pkg::mode_t st_mode;
  logic          st_emit;
  logic [3:0]    st_kind;
  logic [PB-1:0] st_begin;
  logic [7:0]    st_op;
  logic [1:0]    st_kw;

  // e0: token closed by the pending mode; e1: token from the byte itself or EOF.
  logic          e0_v, e1_v;
  logic [3:0]    e0_kind, e1_kind;
  logic [15:0]   e0_start, e1_start, e0_len, e1_len;
  logic          take_start;

  expr_tok_pkg::out_t wr0, wr1;
  logic [1:0]         n_push;

  assign c        = in_data.ch;
  assign text_end = in_data.end_of_text || c == expr_tok_pkg::CH_NUL;
  assign p        = cursor_r;
  assign span16   = (p >= tok_begin_r) ? 16'(p - tok_begin_r) : 16'd0;

  assign in_stall  = count_r > (AW+1)'(expr_tok_pkg::OUT_DEPTH - 2);
  assign push      = in_valid && !in_stall;
  assign out_valid = count_r != '0;
  assign pop       = out_valid && !out_stall;
  assign out_data  = fifo_r[rd_ptr_r];

  always_comb begin
    st_mode  = expr_tok_pkg::MODE_IDLE;
    st_emit  = 1'b0;
    st_kind  = expr_tok_pkg::KIND_BADCHAR;
    st_begin = tok_begin_r;
    st_op    = op_char_r;
    st_kw    = kw_r;
    if (is_space(c)) begin
      st_mode = expr_tok_pkg::MODE_IDLE;
    end else if (c == expr_tok_pkg::CH_QUOTE) begin
      st_mode  = expr_tok_pkg::MODE_STRING;
      st_begin = sat_inc(p);
    end else if (is_alpha(c)) begin
      st_mode  = expr_tok_pkg::MODE_IDENT;
      st_begin = p;
      st_kw    = (c == expr_tok_pkg::CH_LOWER_I) ? expr_tok_pkg::KW_SAW_I
                                                : expr_tok_pkg::KW_OTHER;
    end else if (is_digit(c)) begin
      st_mode  = expr_tok_pkg::MODE_NUMBER;
      st_begin = p;
    end else if (c == expr_tok_pkg::CH_LPAREN) begin
      st_emit = 1'b1;
      st_kind = expr_tok_pkg::KIND_LPAREN;
    end else if (c == expr_tok_pkg::CH_RPAREN) begin
      st_emit = 1'b1;
      st_kind = expr_tok_pkg::KIND_RPAREN;
    end else if (c == expr_tok_pkg::CH_LBRACKET) begin
      st_emit = 1'b1;
      st_kind = expr_tok_pkg::KIND_LBRACKET;
    end else if (c == expr_tok_pkg::CH_RBRACKET) begin
      st_emit = 1'b1;
      st_kind = expr_tok_pkg::KIND_RBRACKET;
    end else if (c == expr_tok_pkg::CH_COMMA) begin
      st_emit = 1'b1;
      st_kind = expr_tok_pkg::KIND_COMMA;
    end else if (is_opchar(c)) begin
      st_mode  = expr_tok_pkg::MODE_OP;
      st_op    = c;
      st_begin = p;
    end else begin
      st_emit = 1'b1;
      st_kind = expr_tok_pkg::KIND_BADCHAR;
      st_mode = expr_tok_pkg::MODE_ERROR;
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    tok_begin_nxt = tok_begin_r;
    op_char_nxt   = op_char_r;
    kw_nxt        = kw_r;
    cursor_nxt    = sat_inc(p);
    take_start    = 1'b0;
    e0_v          = 1'b0;
    e0_kind       = expr_tok_pkg::KIND_EOF;
    e0_start      = 16'(tok_begin_r);
    e0_len        = span16;
    e1_v          = 1'b0;
    e1_kind       = st_kind;
    e1_start      = 16'(p);
    e1_len        = 16'd1;

    if (text_end) begin
      case (mode_r)
        expr_tok_pkg::MODE_IDENT: begin
          e0_v    = 1'b1;
          e0_kind = (kw_r == expr_tok_pkg::KW_MATCH) ? expr_tok_pkg::KIND_IF
                                                     : expr_tok_pkg::KIND_IDENT;
        end
        expr_tok_pkg::MODE_NUMBER: begin
          e0_v    = 1'b1;
          e0_kind = expr_tok_pkg::KIND_NUMBER;
        end
        expr_tok_pkg::MODE_OP: begin
          e0_v    = 1'b1;
          e0_kind = expr_tok_pkg::KIND_OP;
          e0_len  = 16'd1;
        end
        expr_tok_pkg::MODE_STRING: begin
          e0_v    = 1'b1;
          e0_kind = expr_tok_pkg::KIND_UNCLOSED;
        end
        default: begin
          e0_v = 1'b0;
        end
      endcase
      e1_v          = 1'b1;
      e1_kind       = expr_tok_pkg::KIND_EOF;
      e1_len        = 16'd0;
      mode_nxt      = expr_tok_pkg::MODE_IDLE;
      cursor_nxt    = '0;
      tok_begin_nxt = '0;
      op_char_nxt   = '0;
      kw_nxt        = expr_tok_pkg::KW_NONE;
    end else begin
      case (mode_r)
        expr_tok_pkg::MODE_IDENT: begin
          if (is_alpha(c) || is_digit(c) || c == expr_tok_pkg::CH_UNDER) begin
            kw_nxt = (kw_r == expr_tok_pkg::KW_SAW_I && c == expr_tok_pkg::CH_LOWER_F)
                     ? expr_tok_pkg::KW_MATCH : expr_tok_pkg::KW_OTHER;
          end else begin
            e0_v       = 1'b1;
            e0_kind    = (kw_r == expr_tok_pkg::KW_MATCH) ? expr_tok_pkg::KIND_IF
                                                          : expr_tok_pkg::KIND_IDENT;
            take_start = 1'b1;
          end
        end
        expr_tok_pkg::MODE_NUMBER: begin
          if (!is_digit(c)) begin
            e0_v       = 1'b1;
            e0_kind    = expr_tok_pkg::KIND_NUMBER;
            take_start = 1'b1;
          end
        end
        expr_tok_pkg::MODE_STRING: begin
          if (c == expr_tok_pkg::CH_QUOTE) begin
            e0_v     = 1'b1;
            e0_kind  = expr_tok_pkg::KIND_STRING;
            mode_nxt = expr_tok_pkg::MODE_IDLE;
          end
        end
        expr_tok_pkg::MODE_OP: begin
          e0_v = 1'b1;
          if ((op_char_r == expr_tok_pkg::CH_AMP && c == expr_tok_pkg::CH_AMP) ||
              (op_char_r == expr_tok_pkg::CH_PIPE && c == expr_tok_pkg::CH_PIPE)) begin
            e0_kind  = expr_tok_pkg::KIND_BOOLOP;
            e0_len   = 16'd2;
            mode_nxt = expr_tok_pkg::MODE_IDLE;
          end else if (c == expr_tok_pkg::CH_EQ) begin
            e0_kind  = expr_tok_pkg::KIND_OP;
            e0_len   = 16'd2;
            mode_nxt = expr_tok_pkg::MODE_IDLE;
          end else begin
            e0_kind    = expr_tok_pkg::KIND_OP;
            e0_len     = 16'd1;
            take_start = 1'b1;
          end
        end
        expr_tok_pkg::MODE_ERROR: begin
          mode_nxt = expr_tok_pkg::MODE_ERROR;
        end
        default: begin
          take_start = 1'b1;
        end
      endcase

      // A byte that ends a token without belonging to it also opens the next one in the same pass.
      if (take_start) begin
        mode_nxt      = st_mode;
        tok_begin_nxt = st_begin;
        op_char_nxt   = st_op;
        kw_nxt        = st_kw;
        e1_v          = st_emit;
      end
    end
  end

  always_comb begin
    wr0.kind        = e0_v ? e0_kind  : e1_kind;
    wr0.start_res   = e0_v ? e0_start : e1_start;
    wr0.length      = e0_v ? e0_len   : e1_len;
    wr0.last_of_run = !(e0_v && e1_v);
    wr1.kind        = e1_kind;
    wr1.start_res   = e1_start;
    wr1.length      = e1_len;
    wr1.last_of_run = 1'b1;
    n_push          = push ? ({1'b0, e0_v} + {1'b0, e1_v}) : 2'd0;
    wr_ptr_nxt      = wr_ptr_r + AW'(n_push);
    rd_ptr_nxt      = rd_ptr_r + AW'(pop);
    count_nxt       = count_r + (AW+1)'(n_push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= expr_tok_pkg::MODE_IDLE;
      cursor_r    <= '0;
      tok_begin_r <= '0;
      op_char_r   <= '0;
      kw_r        <= expr_tok_pkg::KW_NONE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
    end else begin
      if (push) begin
        mode_r      <= mode_nxt;
        cursor_r    <= cursor_nxt;
        tok_begin_r <= tok_begin_nxt;
        op_char_r   <= op_char_nxt;
        kw_r        <= kw_nxt;
      end
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      fifo_r[wr_ptr_r] <= wr0;
    end
    if (n_push == 2'd2) begin
      fifo_r[wr_ptr_r + 1'b1] <= wr1;
    end
  end

endmodule
